// ----- sv/lfia_pkg.sv -----
package lfia_pkg;

  // default identifier width and fixed field widths of the channels
  localparam int unsigned IdBitsDef = 10;
  localparam int unsigned OpW       = 2;
  localparam int unsigned IdInW     = 10;
  localparam int unsigned NextW     = 10;

  // operation codes
  typedef enum logic [OpW-1:0] {
    OP_REGISTER   = 2'd0,
    OP_UNREGISTER = 2'd1,
    OP_LOOKUP     = 2'd2,
    OP_RESERVED   = 2'd3
  } op_e;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_DRAIN,
    ST_OUTPUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic accept;
    logic clr_wr;
    logic update;
    logic scan_rd;
    logic row_inc;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic row_last;
    logic empty_next;
  } sts_t;

endpackage

// ----- sv/lfia_in_if.sv -----
interface lfia_in_if import lfia_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OpW-1:0]   op;
  logic [IdInW-1:0] id;

  modport source (output valid, output op, output id, input ready);
  modport sink (input valid, input op, input id, output ready);
endinterface

// ----- sv/lfia_out_if.sv -----
interface lfia_out_if import lfia_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             was_present;
  logic [NextW-1:0] next_id;
  logic             no_free_id;

  modport source (output valid, output was_present, output next_id, output no_free_id,
                  input ready);
  modport sink (input valid, input was_present, input next_id, input no_free_id,
                output ready);
endinterface

// ----- sv/lfia_ram.sv -----
module lfia_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/lfia_ctrl.sv -----
module lfia_ctrl import lfia_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr  = 1'b1;
        cmd_o.row_inc = 1'b1;
        if (sts_i.row_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = sts_i.empty_next ? ST_OUTPUT : ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        cmd_o.row_inc = 1'b1;
        if (sts_i.row_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

// ----- sv/lfia_dp.sv -----
module lfia_dp import lfia_pkg::*; #(
  parameter int unsigned IdBits = IdBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  lfia_in_if.sink           in_i,
  lfia_out_if.source        out_o,
  input  cmd_t              cmd_i,
  output sts_t              sts_o
);

  // map organized as rows of up to 32 bits
  localparam int unsigned WordLog  = (IdBits > 5) ? 5 : IdBits - 1;
  localparam int unsigned WordBits = 1 << WordLog;
  localparam int unsigned RowBits  = IdBits - WordLog;
  localparam int unsigned Rows     = 1 << RowBits;

  logic [RowBits-1:0]   row_q;
  logic [IdBits:0]      count_q, count_d;
  op_e                  op_q;
  logic [IdBits-1:0]    id_q;
  logic                 was_q;
  logic                 proc_v_q;
  logic [RowBits-1:0]   proc_row_q;
  logic                 any_q;
  logic [IdBits-1:0]    hi_q;
  logic                 gap_found_q;
  logic [IdBits-1:0]    gap_q;
  logic                 out_valid_q;
  logic                 out_was_q;
  logic [NextW-1:0]     out_next_q;
  logic                 out_full_q;

  logic [IdBits+IdInW-1:0] in_id_ext;
  logic [IdBits-1:0]       in_id;
  logic [WordBits-1:0]     rdata;
  logic [WordBits-1:0]     row_new;
  logic [WordLog-1:0]      bit_idx;
  logic                    was;
  logic                    ram_we;
  logic [RowBits-1:0]      ram_waddr;
  logic [WordBits-1:0]     ram_wdata;
  logic [RowBits-1:0]      ram_raddr;
  logic                    row_nz;
  logic [WordLog-1:0]      low_set;
  logic [WordLog-1:0]      high_set;
  logic [WordLog-1:0]      offset;
  logic [WordBits-1:0]     zeros;
  logic [WordLog-1:0]      zero_first;
  logic [IdBits-1:0]       next_val;
  logic                    full_val;
  logic [IdBits+NextW-1:0] next_ext;

  // input id reduced to the identifier width
  assign in_id_ext = {{IdBits{1'b0}}, in_i.id};
  assign in_id     = in_id_ext[IdBits-1:0];
  assign in_i.ready = cmd_i.in_ready;

  // bitmap memory
  assign bit_idx   = id_q[WordLog-1:0];
  assign was       = rdata[bit_idx];
  assign ram_we    = cmd_i.clr_wr | cmd_i.update;
  assign ram_waddr = cmd_i.clr_wr ? row_q : id_q[IdBits-1:WordLog];
  assign ram_wdata = cmd_i.clr_wr ? '0 : row_new;
  assign ram_raddr = cmd_i.accept ? in_id[IdBits-1:WordLog] : row_q;

  lfia_ram #(
    .Width (WordBits),
    .Depth (Rows)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.accept | cmd_i.scan_rd),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  // row and count after the operation
  always_comb begin
    row_new = rdata;
    count_d = count_q;
    if (op_q == OP_REGISTER && !was) begin
      row_new[bit_idx] = 1'b1;
      count_d          = count_q + {{IdBits{1'b0}}, 1'b1};
    end else if (op_q == OP_UNREGISTER && was) begin
      row_new[bit_idx] = 1'b0;
      count_d          = count_q - {{IdBits{1'b0}}, 1'b1};
    end
  end

  // per-row search: lowest and highest set bits, first clear bit in span
  always_comb begin
    row_nz     = |rdata;
    low_set    = '0;
    high_set   = '0;
    zero_first = '0;
    for (int b = WordBits - 1; b >= 0; b--) begin
      if (rdata[b]) low_set = WordLog'(b);
    end
    for (int b = 0; b < WordBits; b++) begin
      if (rdata[b]) high_set = WordLog'(b);
    end
    offset = any_q ? '0 : low_set;
    for (int b = 0; b < WordBits; b++) begin
      zeros[b] = ~rdata[b] & (WordLog'(b) >= offset);
    end
    for (int b = WordBits - 1; b >= 0; b--) begin
      if (zeros[b]) zero_first = WordLog'(b);
    end
  end

  // row counter, item and scan trackers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      count_q     <= '0;
      proc_v_q    <= 1'b0;
      any_q       <= 1'b0;
      gap_found_q <= 1'b0;
    end else begin
      proc_v_q <= cmd_i.scan_rd;
      if (cmd_i.row_inc) begin
        row_q <= row_q + {{(RowBits-1){1'b0}}, 1'b1};
      end
      if (cmd_i.update) begin
        count_q     <= count_d;
        any_q       <= 1'b0;
        gap_found_q <= 1'b0;
      end else if (proc_v_q) begin
        if (row_nz) begin
          any_q <= 1'b1;
        end
        if (!gap_found_q && (any_q || row_nz) && (|zeros)) begin
          gap_found_q <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q <= op_e'(in_i.op);
      id_q <= in_id;
    end
    if (cmd_i.update) begin
      was_q <= was;
    end
    if (cmd_i.scan_rd) begin
      proc_row_q <= row_q;
    end
    if (proc_v_q && !cmd_i.update) begin
      if (row_nz) begin
        hi_q <= {proc_row_q, high_set};
      end
      if (!gap_found_q && (any_q || row_nz) && (|zeros)) begin
        gap_q <= {proc_row_q, zero_first};
      end
    end
  end

  // next identifier from the trackers
  always_comb begin
    full_val = 1'b0;
    if (!any_q) begin
      next_val = {{(IdBits-1){1'b0}}, 1'b1};
    end else if (gap_found_q && (gap_q < hi_q)) begin
      next_val = gap_q;
    end else if (&hi_q) begin
      next_val = '0;
      full_val = 1'b1;
    end else begin
      next_val = hi_q + {{(IdBits-1){1'b0}}, 1'b1};
    end
  end

  assign next_ext = {{NextW{1'b0}}, next_val};

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_was_q  <= was_q;
      out_next_q <= next_ext[NextW-1:0];
      out_full_q <= full_val;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.was_present = out_was_q;
  assign out_o.next_id     = out_next_q;
  assign out_o.no_free_id  = out_full_q;

  // status
  assign sts_o.in_valid   = in_i.valid;
  assign sts_o.out_free   = ~out_valid_q | out_o.ready;
  assign sts_o.row_last   = &row_q;
  assign sts_o.empty_next = (count_d == '0);

endmodule

// ----- sv/lowest_free_id_allocator.sv -----
// channel  dir  payload                                transfer
// in_i     in   op[1:0], id[9:0]                       valid & ready
// out_o    out  was_present, next_id[9:0], no_free_id  valid & ready
//
// an item reads the map one row of up to 32 bits per cycle through a single memory
// read port, 2^(ID_BITS-5) rows, two rows below 6 bits; with no ID registered the
// scan is skipped; after reset a clearing pass writes every row, one per cycle,
// with in_i.ready low
// one item is in work at a time; a finished result waits in the output register
// while the next item is taken, and holds that item in its last cycle until it leaves
module lowest_free_id_allocator import lfia_pkg::*; #(
  parameter int unsigned ID_BITS = IdBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lfia_in_if.sink    in_i,
  lfia_out_if.source out_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  lfia_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // map, search and result registers
  lfia_dp #(
    .IdBits (ID_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule

// ----- tb/sv/lowest_free_id_allocator_test.sv -----
`timescale 1ns / 1ps

module lowest_free_id_allocator_test import lfia_pkg::*;;

  localparam int NumIds      = 1 << IdBitsDef;
  localparam int RandItems   = 850;
  localparam int CycleLimit  = 600000;
  // long enough to cover any late result
  localparam int SettleCycles = 80;

  typedef struct packed {
    logic             was_present;
    logic [NextW-1:0] next_id;
    logic             no_free_id;
  } alloc_result_t;

  typedef struct {
    op_e              op;
    logic [IdInW-1:0] id;
    bit               typed;
    alloc_result_t    res;
  } stim_row_t;

  logic clk;
  logic rst_n;

  lfia_in_if  in_ch ();
  lfia_out_if out_ch ();

  lowest_free_id_allocator DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // predicted id map and results still owed by the block
  bit [NumIds-1:0] id_map;
  alloc_result_t   owed_q[$];
  stim_row_t       dir_rows[$];

  // typed expectation that travels with the payload of a directed row
  bit              row_typed;
  alloc_result_t   row_res;

  bit              send_quiet;
  int unsigned     errors;
  int unsigned     cycles;
  int unsigned     n_results;
  int unsigned     n_full;
  int unsigned     n_present;
  int unsigned     n_empty;
  int unsigned     op_seen[4];

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // lowest free id inside the registered span, or the one after it; 1 on an empty map
  function automatic void next_free(output logic [NextW-1:0] nxt, output logic full);
    int lo;
    int hi;
    bit any;
    lo   = 0;
    hi   = 0;
    any  = 1'b0;
    nxt  = NextW'(1);
    full = 1'b0;
    for (int i = 0; i < NumIds; i++) begin
      if (id_map[i]) begin
        if (!any) lo = i;
        any = 1'b1;
        hi  = i;
      end
    end
    if (!any) return;
    for (int i = lo; i <= hi; i++) begin
      if (!id_map[i]) begin
        nxt = NextW'(i);
        return;
      end
    end
    if (hi == NumIds - 1) begin
      full = 1'b1;
      nxt  = '0;
    end else begin
      nxt = NextW'(hi + 1);
    end
  endfunction

  // apply one operation to the predicted map and return its result
  function automatic alloc_result_t apply_op(op_e op, logic [IdInW-1:0] id);
    alloc_result_t    r;
    logic [NextW-1:0] nxt;
    logic             full;
    int               idx;
    idx = int'(id) & (NumIds - 1);
    r.was_present = id_map[idx];
    if (op == OP_REGISTER) begin
      id_map[idx] = 1'b1;
    end else if (op == OP_UNREGISTER) begin
      id_map[idx] = 1'b0;
    end
    next_free(nxt, full);
    r.next_id    = nxt;
    r.no_free_id = full;
    return r;
  endfunction

  function automatic void add_row(op_e op, logic [IdInW-1:0] id, bit typed,
                                  logic was, int nxt, logic full);
    stim_row_t row;
    row.op    = op;
    row.id    = id;
    row.typed = typed;
    row.res   = '{was, NextW'(nxt), full};
    dir_rows  = {dir_rows, row};
  endfunction

  // one transfer on the input channel, then a random gap
  task automatic send_item(op_e op, logic [IdInW-1:0] id, bit typed, alloc_result_t res);
    int unsigned gap;
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.id    <= id;
    row_typed   <= typed;
    row_res     <= res;
    do @(posedge clk); while (!in_ch.ready);
    gap = 0;
    if (!send_quiet) begin
      case ($urandom_range(0, 19)) inside
        0:             gap = $urandom_range(10, 40);
        [1:4]:         gap = $urandom_range(1, 4);
        default:       gap = 0;
      endcase
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the sender until every owed result has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (owed_q.size() != 0);
  endtask

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d results owed", $time, cycles,
               owed_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  // predict on each input transfer, compare on each output transfer
  always @(posedge clk) begin : check_results
    alloc_result_t want;
    alloc_result_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        want = apply_op(op_e'(in_ch.op), in_ch.id);
        op_seen[in_ch.op]++;
        if (row_typed) want = row_res;
        owed_q = {owed_q, want};
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.was_present, out_ch.next_id, out_ch.no_free_id};
        n_results++;
        if (owed_q.size() == 0) begin
          $display("%0t: result with nothing owed: was_present %0d next_id %0d no_free_id %0d",
                   $time, got.was_present, got.next_id, got.no_free_id);
          errors++;
        end else begin
          want = owed_q.pop_front();
          if (got.was_present !== want.was_present) begin
            $display("%0t: was_present expected %0d actual %0d", $time,
                     want.was_present, got.was_present);
            errors++;
          end
          if (got.next_id !== want.next_id) begin
            $display("%0t: next_id expected %0d actual %0d", $time, want.next_id, got.next_id);
            errors++;
          end
          if (got.no_free_id !== want.no_free_id) begin
            $display("%0t: no_free_id expected %0d actual %0d", $time,
                     want.no_free_id, got.no_free_id);
            errors++;
          end
          if (want.no_free_id) n_full++;
          if (want.was_present) n_present++;
          if (!want.no_free_id && want.next_id == NextW'(1)) n_empty++;
        end
      end
    end
  end

  // output side: random stalls, with quiet stretches
  initial begin : drive_ready
    int unsigned stall_left;
    int unsigned stretch_left;
    bit          quiet;
    stall_left   = 0;
    stretch_left = 0;
    quiet        = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stretch_left == 0) begin
        quiet        = ($urandom_range(0, 3) == 0);
        stretch_left = $urandom_range(20, 200);
      end
      stretch_left--;
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 9) < 3) begin
          stall_left = ($urandom_range(0, 19) < 3) ? $urandom_range(10, 80)
                                                   : $urandom_range(1, 4);
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int unsigned      sent;
    int unsigned      base;
    int unsigned      span;
    int unsigned      len;
    int unsigned      pick;
    logic [NextW-1:0] nxt;
    logic             full;
    logic [IdInW-1:0] id;
    op_e              op;

    id_map     = '0;
    errors     = 0;
    cycles     = 0;
    send_quiet = 1'b0;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.op    <= OP_LOOKUP;
    in_ch.id    <= '0;
    row_typed   <= 1'b0;
    row_res     <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows: empty map, top of range, gaps, repeats, reserved op
    add_row(OP_LOOKUP,     10'd0,    1, 0, 1,   0);
    add_row(OP_REGISTER,   10'd1023, 1, 0, 0,   1);
    add_row(OP_REGISTER,   10'd0,    1, 0, 1,   0);
    add_row(OP_RESERVED,   10'd1023, 1, 1, 1,   0);
    add_row(OP_UNREGISTER, 10'd1023, 1, 1, 1,   0);
    add_row(OP_UNREGISTER, 10'd1023, 1, 0, 1,   0);
    add_row(OP_REGISTER,   10'd0,    1, 1, 1,   0);
    add_row(OP_REGISTER,   10'd1,    1, 0, 2,   0);
    add_row(OP_REGISTER,   10'd3,    1, 0, 2,   0);
    add_row(OP_REGISTER,   10'd2,    1, 0, 4,   0);
    add_row(OP_UNREGISTER, 10'd0,    1, 1, 4,   0);
    add_row(OP_UNREGISTER, 10'd2,    1, 1, 2,   0);
    add_row(OP_UNREGISTER, 10'd1,    1, 1, 4,   0);
    add_row(OP_UNREGISTER, 10'd3,    1, 1, 1,   0);
    add_row(OP_REGISTER,   10'h2AA,  0, 0, 0,   0);
    add_row(OP_REGISTER,   10'h155,  0, 0, 0,   0);
    add_row(OP_LOOKUP,     10'h155,  0, 0, 0,   0);
    add_row(OP_UNREGISTER, 10'h2AA,  0, 0, 0,   0);
    add_row(OP_UNREGISTER, 10'h155,  1, 1, 1,   0);
    add_row(OP_REGISTER,   10'd1022, 1, 0, 1023, 0);
    add_row(OP_REGISTER,   10'd1023, 1, 0, 0,   1);
    add_row(OP_LOOKUP,     10'd1022, 1, 1, 0,   1);
    add_row(OP_UNREGISTER, 10'd1022, 1, 1, 0,   1);
    add_row(OP_UNREGISTER, 10'd1023, 1, 1, 1,   0);
    add_row(OP_RESERVED,   10'd0,    1, 0, 1,   0);
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].op, dir_rows[i].id, dir_rows[i].typed, dir_rows[i].res);
    end
    wait_drained();

    // random phases: allocation traffic inside a window of ids
    sent = 0;
    while (sent < RandItems) begin
      case ($urandom_range(0, 3))
        0:       span = 4;
        1:       span = 8;
        2:       span = 16;
        default: span = 64;
      endcase
      case ($urandom_range(0, 3))
        0:       base = 0;
        1:       base = NumIds - span;
        default: base = $urandom_range(0, NumIds - span);
      endcase
      send_quiet = ($urandom_range(0, 3) == 0);
      len = $urandom_range(15, 60);
      repeat (len) begin
        pick = $urandom_range(0, 99);
        id   = IdInW'(base + $urandom_range(0, span - 1));
        if (pick < 30) begin
          // take the id the block would hand out
          op = OP_REGISTER;
          next_free(nxt, full);
          if (!full && nxt >= base && nxt < base + span) id = nxt;
        end else if (pick < 45) begin
          op = OP_REGISTER;
        end else if (pick < 75) begin
          // mostly release an id that is held
          op = OP_UNREGISTER;
          for (int t = 0; t < 4 && !id_map[id]; t++) begin
            id = IdInW'(base + $urandom_range(0, span - 1));
          end
        end else if (pick < 92) begin
          op = OP_LOOKUP;
        end else if (pick < 96) begin
          op = OP_RESERVED;
        end else begin
          // noise anywhere in the id range
          op = op_e'($urandom_range(0, 3));
          id = IdInW'($urandom_range(0, NumIds - 1));
        end
        send_item(op, id, 1'b0, '0);
        sent++;
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
      // release everything so the map starts empty again
      if ($urandom_range(0, 2) == 0) begin
        for (int i = 0; i < NumIds; i++) begin
          if (id_map[i]) begin
            send_item(OP_UNREGISTER, IdInW'(i), 1'b0, '0);
            sent++;
          end
        end
      end
    end

    // drain and watch for stray results
    send_quiet = 1'b1;
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (owed_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, owed_q.size());
      errors++;
    end
    $display("checked %0d results: %0d range exhausted, %0d on held ids, %0d next id 1",
             n_results, n_full, n_present, n_empty);
    $display("ops: %0d register, %0d unregister, %0d lookup, %0d reserved; %0d errors",
             op_seen[OP_REGISTER], op_seen[OP_UNREGISTER], op_seen[OP_LOOKUP],
             op_seen[OP_RESERVED], errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
